FILE: rtl/ccs_pkg.sv
// ----------------------------------------------------------------------------
// Comment stripper package
// Shared types and character constants for the comment stripper blocks.
// ----------------------------------------------------------------------------
package ccs_pkg;

  localparam int RUN_FIFO_DEPTH = 4;
  localparam int RUN_MAX        = 3;

  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_NUL     = 8'h00;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'b001,
    MODE_LINE   = 3'b010,
    MODE_BLOCK  = 3'b100
  } scan_mode_t;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       is_terminator;
    logic       last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       term;
  } res_t;

  typedef struct packed {
    res_t [RUN_MAX-1:0] res;
    logic [1:0]         last_idx;
  } run_t;

  typedef struct packed {
    logic valid;
    run_t run;
  } run_push_t;

endpackage

FILE: rtl/ccs_front.sv
// ----------------------------------------------------------------------------
// Comment stripper front end
// Accepts text bytes, tracks comment and quote state, and builds one run of
// up to three results per byte.
// ----------------------------------------------------------------------------
module ccs_front import ccs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  in_item_t  in_data,
  input  logic      fifo_full,
  output run_push_t push
);

  scan_mode_t mode_r, mode_nxt;
  logic       la_r, la_nxt;
  logic       par_r, par_nxt;
  logic       accept;
  logic       do_normal;
  logic       pre_slash;
  logic       byte_emit;
  logic       flush_slash;
  logic [7:0] c;
  logic       eot;
  res_t       cand [4];
  logic [3:0] cand_v;
  res_t       slot [RUN_MAX];
  logic [1:0] n;

  assign c      = in_data.char_in;
  assign eot    = in_data.end_of_text;
  assign accept = in_valid && !fifo_full;

  always_comb begin
    mode_nxt  = mode_r;
    la_nxt    = la_r;
    par_nxt   = par_r;
    do_normal = 1'b0;
    pre_slash = 1'b0;
    byte_emit = 1'b0;
    unique case (mode_r)
      MODE_LINE: begin
        if (c == CH_NEWLINE) begin
          mode_nxt  = MODE_NORMAL;
          byte_emit = 1'b1;
        end
      end
      MODE_BLOCK: begin
        if (la_r && (c == CH_SLASH)) begin
          mode_nxt = MODE_NORMAL;
          la_nxt   = 1'b0;
        end else begin
          la_nxt = (c == CH_STAR);
        end
      end
      default: begin
        if (la_r) begin
          la_nxt = 1'b0;
          if (c == CH_SLASH) begin
            mode_nxt = MODE_LINE;
          end else if (c == CH_STAR) begin
            mode_nxt = MODE_BLOCK;
          end else begin
            pre_slash = 1'b1;
            do_normal = 1'b1;
          end
        end else begin
          do_normal = 1'b1;
        end
      end
    endcase
    if (do_normal) begin
      if (c == CH_QUOTE) begin
        par_nxt   = ~par_r;
        byte_emit = 1'b1;
      end else if (par_r) begin
        byte_emit = 1'b1;
      end else if (c == CH_SLASH) begin
        la_nxt = 1'b1;
      end else begin
        byte_emit = 1'b1;
      end
    end
    flush_slash = eot && (mode_nxt != MODE_LINE) && (mode_nxt != MODE_BLOCK) && la_nxt;
    if (eot) begin
      mode_nxt = MODE_NORMAL;
      la_nxt   = 1'b0;
      par_nxt  = 1'b0;
    end
  end

  always_comb begin
    cand[0]   = '{ch: CH_SLASH, term: 1'b0};
    cand[1]   = '{ch: c,        term: 1'b0};
    cand[2]   = '{ch: CH_SLASH, term: 1'b0};
    cand[3]   = '{ch: CH_NUL,   term: 1'b1};
    cand_v    = {eot, flush_slash, byte_emit, pre_slash};
    slot[0]   = '0;
    slot[1]   = '0;
    slot[2]   = '0;
    n         = 2'd0;
    for (int k = 0; k < 4; k++) begin
      if (cand_v[k]) begin
        unique case (n)
          2'd0:    slot[0] = cand[k];
          2'd1:    slot[1] = cand[k];
          2'd2:    slot[2] = cand[k];
          default: ;
        endcase
        n = n + 2'd1;
      end
    end
    push.valid        = accept && (n != 2'd0);
    push.run.res[0]   = slot[0];
    push.run.res[1]   = slot[1];
    push.run.res[2]   = slot[2];
    push.run.last_idx = n - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NORMAL;
      la_r   <= 1'b0;
      par_r  <= 1'b0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      la_r   <= la_nxt;
      par_r  <= par_nxt;
    end
  end

endmodule

FILE: rtl/ccs_run_fifo.sv
// ----------------------------------------------------------------------------
// Comment stripper run queue
// Short queue of result runs between the front end and the output stage.
// ----------------------------------------------------------------------------
module ccs_run_fifo import ccs_pkg::*; #(
  parameter int DEPTH = RUN_FIFO_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  run_push_t push,
  input  logic      pop,
  output logic      full,
  output logic      not_empty,
  output run_t      rd_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  run_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign rd_data   = mem_r[rd_ptr_r];
  assign do_push   = push.valid && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.run;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/ccs_back.sv
// ----------------------------------------------------------------------------
// Comment stripper output stage
// Takes runs from the queue and delivers their results one per transaction.
// ----------------------------------------------------------------------------
module ccs_back import ccs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      fifo_not_empty,
  input  run_t      fifo_data,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic       busy_r;
  run_t       run_r;
  logic [1:0] idx_r;
  logic       out_accept;
  logic       last;
  res_t       cur;

  always_comb begin
    unique case (idx_r)
      2'd0:    cur = run_r.res[0];
      2'd1:    cur = run_r.res[1];
      default: cur = run_r.res[2];
    endcase
  end

  assign last                   = (idx_r == run_r.last_idx);
  assign out_valid              = busy_r;
  assign out_data.char_out      = cur.ch;
  assign out_data.is_terminator = cur.term;
  assign out_data.last_of_run   = last;
  assign out_accept             = busy_r && !out_stall;
  assign pop                    = fifo_not_empty && (!busy_r || (out_accept && last));

  always_ff @(posedge clk) begin
    if (pop) begin
      run_r <= fifo_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 2'd0;
    end else if (pop) begin
      busy_r <= 1'b1;
      idx_r  <= 2'd0;
    end else if (out_accept) begin
      if (last) begin
        busy_r <= 1'b0;
      end else begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

endmodule

FILE: rtl/c_comment_stripper.sv
// ----------------------------------------------------------------------------
// C comment stripper
// Removes line and block comments from a byte stream, honoring quotes.
// ----------------------------------------------------------------------------
// Input bytes arrive on in_valid/in_stall with in_data; the last byte of a
// text carries end_of_text. Kept bytes leave on out_valid/out_stall, and each
// text ends with a terminator transaction (char_out zero, is_terminator set).
// last_of_run marks the final result that one input byte produced.
// Each accepted byte is classified in the cycle it is accepted and its run
// of one to three results is written to a FIFO_DEPTH entry queue; a byte
// with no results writes nothing. The output stage loads a run from the
// queue into its run register and offers the results from there.
// The output stage then delivers one result per cycle while out_stall is low and runs are queued.
// A byte is accepted every cycle while the queue has room; the output
// stage's one result per cycle sets the sustained rate when bytes produce
// more than one result each.
// When the receiver stalls, the current result holds and the queue fills;
// in_stall rises once it is full.
// Reset clears the comment state, the queue and the output stage.
// ----------------------------------------------------------------------------
module c_comment_stripper import ccs_pkg::*; #(
  parameter int FIFO_DEPTH = RUN_FIFO_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic      fifo_full;
  logic      fifo_not_empty;
  logic      pop;
  run_push_t push;
  run_t      fifo_data;

  assign in_stall = fifo_full;

  ccs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .fifo_full (fifo_full),
    .push      (push)
  );

  ccs_run_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pop       (pop),
    .full      (fifo_full),
    .not_empty (fifo_not_empty),
    .rd_data   (fifo_data)
  );

  ccs_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .fifo_not_empty (fifo_not_empty),
    .fifo_data      (fifo_data),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data)
  );

endmodule

FILE: rtl/ccs_checker.sv
// ----------------------------------------------------------------------------
// Comment stripper checker
// Port-level assertions on the comment stripper, attached by bind.
// ----------------------------------------------------------------------------
module ccs_checker import ccs_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("Stalled output transaction changed.");

  a_term_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_terminator |->
      out_data.last_of_run && (out_data.char_out == CH_NUL))
    else $error("Terminator transaction is malformed.");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Output valid after reset.");

  a_no_drop_first: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.end_of_text |=> ##1 out_valid)
    else $error("No result after an end of text transaction.");

endmodule

bind c_comment_stripper ccs_checker u_ccs_checker (.*);

FILE: test/c_comment_stripper_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// C comment stripper testbench
// Feeds short texts, first hand-picked and then randomly built from comment,
// quote and plain tokens, and checks every kept byte and terminator against a
// behavioral model of the stripper. Both channels idle in random bursts.
// ----------------------------------------------------------------------------
module c_comment_stripper_tb;
  import ccs_pkg::*;

  localparam int TOTAL_ITEMS    = 430;
  localparam int DRAIN_CYCLES   = 10;
  localparam int WATCHDOG_LIMIT = 1000;

  class strip_scoreboard;
    scan_mode_t mode;
    bit         held;
    bit         odd_quotes;
    out_item_t  kept_q[$];
    out_item_t  run_q[$];
    int         errors;
    int         checked;
    int         terminators;

    function new();
      clear_state();
      errors = 0;
      checked = 0;
      terminators = 0;
    endfunction

    function void clear_state();
      mode = MODE_NORMAL;
      held = 1'b0;
      odd_quotes = 1'b0;
    endfunction

    function void emit_byte(logic [7:0] ch, logic term);
      out_item_t r;
      r.char_out = ch;
      r.is_terminator = term;
      r.last_of_run = 1'b0;
      run_q.push_back(r);
    endfunction

    function void text_byte(logic [7:0] c);
      if (c == CH_QUOTE) begin
        odd_quotes = ~odd_quotes;
        emit_byte(c, 1'b0);
      end else if (odd_quotes || c != CH_SLASH) begin
        emit_byte(c, 1'b0);
      end else begin
        held = 1'b1;
      end
    endfunction

    function void note_input(in_item_t item);
      logic [7:0] c;
      out_item_t  r;
      c = item.char_in;
      run_q.delete();
      case (mode)
        MODE_LINE: begin
          if (c == CH_NEWLINE) begin
            mode = MODE_NORMAL;
            emit_byte(c, 1'b0);
          end
        end
        MODE_BLOCK: begin
          if (held && c == CH_SLASH) begin
            mode = MODE_NORMAL;
            held = 1'b0;
          end else begin
            held = (c == CH_STAR);
          end
        end
        default: begin
          if (held) begin
            held = 1'b0;
            if (c == CH_SLASH) begin
              mode = MODE_LINE;
            end else if (c == CH_STAR) begin
              mode = MODE_BLOCK;
            end else begin
              emit_byte(CH_SLASH, 1'b0);
              text_byte(c);
            end
          end else begin
            text_byte(c);
          end
        end
      endcase
      if (item.end_of_text) begin
        if (mode == MODE_NORMAL && held) emit_byte(CH_SLASH, 1'b0);
        emit_byte(CH_NUL, 1'b1);
        clear_state();
      end
      if (run_q.size() > 0) begin
        r = run_q.pop_back();
        r.last_of_run = 1'b1;
        run_q.push_back(r);
      end
      foreach (run_q[i]) kept_q.push_back(run_q[i]);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (kept_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected transaction, expected none, got char_out=%h term=%b last=%b",
                 $time, got.char_out, got.is_terminator, got.last_of_run);
        return;
      end
      want = kept_q.pop_front();
      checked++;
      if (want.is_terminator) terminators++;
      if (got.char_out !== want.char_out) begin
        errors++;
        $display("%0t: char_out expected %h, got %h", $time, want.char_out, got.char_out);
      end
      if (got.is_terminator !== want.is_terminator) begin
        errors++;
        $display("%0t: is_terminator expected %b, got %b", $time,
                 want.is_terminator, got.is_terminator);
      end
      if (got.last_of_run !== want.last_of_run) begin
        errors++;
        $display("%0t: last_of_run expected %b, got %b", $time,
                 want.last_of_run, got.last_of_run);
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  strip_scoreboard sb;
  logic [7:0] text_q[$];
  bit         idle_enable = 1'b0;
  int         stall_left = 0;
  int         quiet_cycles = 0;
  int         items_sent = 0;
  int         texts_sent = 0;

  c_comment_stripper uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_input(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
    end
  end

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (idle_enable && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(1, 13) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] ch, input logic eot);
    in_item_t item;
    item.char_in = ch;
    item.end_of_text = eot;
    if (idle_enable && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_text(input string s, input logic eot);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], eot && i == s.len() - 1);
    if (eot) texts_sent++;
  endtask

  function automatic logic [7:0] pick_char();
    logic [7:0] b;
    case ($urandom_range(0, 7))
      0: b = CH_SLASH;
      1: b = CH_STAR;
      2: b = CH_QUOTE;
      3: b = CH_NEWLINE;
      4, 5: b = 8'($urandom_range(0, 255));
      default: b = 8'($urandom_range(8'h61, 8'h7a));
    endcase
    return b;
  endfunction

  function automatic void add_token();
    int n;
    n = $urandom_range(0, 6);
    case ($urandom_range(0, 7))
      0: begin
        text_q.push_back(CH_SLASH);
        text_q.push_back(CH_SLASH);
        repeat (n) text_q.push_back(pick_char());
        text_q.push_back(CH_NEWLINE);
      end
      1: begin
        text_q.push_back(CH_SLASH);
        text_q.push_back(CH_STAR);
        repeat (n) text_q.push_back(pick_char());
        text_q.push_back(CH_STAR);
        text_q.push_back(CH_SLASH);
      end
      2: begin
        text_q.push_back(CH_QUOTE);
        repeat (n) text_q.push_back(pick_char());
        text_q.push_back(CH_QUOTE);
      end
      3: begin
        text_q.push_back(CH_SLASH);
        text_q.push_back(pick_char());
      end
      4: text_q.push_back(CH_STAR);
      default: repeat (n + 1) text_q.push_back(pick_char());
    endcase
  endfunction

  initial begin
    int cut;
    bit eot_at_end;
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    idle_enable <= 1'b1;

    send_byte(CH_NUL, 1'b0);
    send_byte(8'hff, 1'b0);
    send_text("/x", 1'b0);
    send_text("/\"/\"", 1'b0);
    send_text("//c\n", 1'b0);
    send_text("/**/", 1'b0);
    send_text("/", 1'b1);
    send_text("/\"", 1'b1);
    send_text("/**", 1'b1);
    send_text("//z", 1'b1);
    send_text("\"q", 1'b1);

    while (items_sent < TOTAL_ITEMS) begin
      idle_enable <= (items_sent < 200) || (items_sent >= 280 && items_sent < 380);
      text_q.delete();
      repeat ($urandom_range(1, 5)) add_token();
      if ($urandom_range(0, 4) == 0) cut = $urandom_range(1, text_q.size());
      else cut = text_q.size();
      eot_at_end = ($urandom_range(0, 7) != 0);
      for (int i = 0; i < cut; i++) send_byte(text_q[i], eot_at_end && i == cut - 1);
      if (eot_at_end) texts_sent++;
    end
    send_byte(8'h3b, 1'b1);
    texts_sent++;
    in_valid <= 1'b0;

    while (sb.kept_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Fed %0d bytes in %0d texts through comments, quotes and held slashes.",
             items_sent, texts_sent);
    $display("Checked %0d output transactions, %0d of them terminators, %0d errors.",
             sb.checked, sb.terminators, sb.errors);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: c_comment_stripper.f
rtl/ccs_pkg.sv
rtl/ccs_front.sv
rtl/ccs_run_fifo.sv
rtl/ccs_back.sv
rtl/c_comment_stripper.sv
rtl/ccs_checker.sv
test/c_comment_stripper_tb.sv
